### hw/rtl/ppc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    // Default field widths.
    localparam int VOLT_BITS_DEF     = 15;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int PRESSURE_BITS_DEF = 16;

    // Depth of the queue between the classifier and the divider side.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_S1_MIN      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_S1_MAX      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_S2_MIN      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_S2_MAX      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIS_LIMIT   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_LEVEL = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LATCH_LEVEL = 3'd6;

    // Configuration reset values, cut to the field widths where used.
    localparam int RESET_S1_MIN      = 2048;
    localparam int RESET_S1_MAX      = 18432;
    localparam int RESET_S2_MIN      = 2048;
    localparam int RESET_S2_MAX      = 18432;
    localparam int RESET_DIS_LIMIT   = 410;
    localparam int RESET_LIGHT_LEVEL = 1000;
    localparam int RESET_LATCH_LEVEL = 4000;

    // Open circuit is 100 * v <= 1.0 V; pedal idle is 10 * (p1 + p2) <= 1.0.
    localparam int OPEN_SCALE = 100;
    localparam int IDLE_SCALE = 10;

    // Classification of one accepted word, decided at the front.
    typedef struct packed {
        logic zero_one;      // sensor one position is 0
        logic sat_one;       // sensor one position saturates at 1.0
        logic zero_two;
        logic sat_two;
        logic open_circuit;  // either sensor at or below 0.01 V
        logic light;         // mean brake pressure at light level
        logic latch_set;     // mean brake pressure at latch level
    } class_t;

    // Divider side sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_FINISH
    } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/ppc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ppc_front #(
    parameter int VOLT_BITS     = ppc_pkg::VOLT_BITS_DEF,
    parameter int FRACTION_BITS = ppc_pkg::FRACTION_BITS_DEF,
    parameter int PRESSURE_BITS = ppc_pkg::PRESSURE_BITS_DEF
) (
    input  wire logic [VOLT_BITS-1:0]     sensor_one_volts,
    input  wire logic [VOLT_BITS-1:0]     sensor_two_volts,
    input  wire logic [PRESSURE_BITS-1:0] front_pressure,
    input  wire logic [PRESSURE_BITS-1:0] rear_pressure,
    input  wire logic [VOLT_BITS-1:0]     s1_min,
    input  wire logic [VOLT_BITS-1:0]     s1_max,
    input  wire logic [VOLT_BITS-1:0]     s2_min,
    input  wire logic [VOLT_BITS-1:0]     s2_max,
    input  wire logic [PRESSURE_BITS-1:0] light_level,
    input  wire logic [PRESSURE_BITS-1:0] latch_level,
    output logic [VOLT_BITS-1:0]          dv_one,
    output logic [VOLT_BITS-1:0]          span_one,
    output logic [VOLT_BITS-1:0]          dv_two,
    output logic [VOLT_BITS-1:0]          span_two,
    output ppc_pkg::class_t               cls
);

    localparam int XW = VOLT_BITS + 7;
    localparam logic [XW-1:0] ONE_VOLT_X = XW'(1) << FRACTION_BITS;

    logic [XW-1:0]            v1_x100;
    logic [XW-1:0]            v2_x100;
    logic [PRESSURE_BITS:0]   psum;

    // Offsets above the released-pedal voltage and calibrated spans.
    assign dv_one   = sensor_one_volts - s1_min;
    assign span_one = s1_max - s1_min;
    assign dv_two   = sensor_two_volts - s2_min;
    assign span_two = s2_max - s2_min;

    // Open-circuit test scaled to stay exact in integers.
    assign v1_x100 = XW'(sensor_one_volts) * XW'(ppc_pkg::OPEN_SCALE);
    assign v2_x100 = XW'(sensor_two_volts) * XW'(ppc_pkg::OPEN_SCALE);

    // Brake tests compare the sum against twice the level.
    assign psum = {1'b0, front_pressure} + {1'b0, rear_pressure};

    // Short-cut cases that need no division, and the open-circuit and brake tests.
    always_comb
    begin
        cls.zero_one     = (s1_max <= s1_min) || (sensor_one_volts <= s1_min);
        cls.sat_one      = dv_one >= span_one;
        cls.zero_two     = (s2_max <= s2_min) || (sensor_two_volts <= s2_min);
        cls.sat_two      = dv_two >= span_two;
        cls.open_circuit = (v1_x100 <= ONE_VOLT_X) || (v2_x100 <= ONE_VOLT_X);
        cls.light        = psum >= {light_level, 1'b0};
        cls.latch_set    = psum >= {latch_level, 1'b0};
    end

endmodule

`default_nettype wire

### hw/rtl/ppc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ppc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ppc_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage words carry no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    // A read is only issued with a word present.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

### hw/rtl/ppc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ppc_back #(
    parameter int VOLT_BITS     = ppc_pkg::VOLT_BITS_DEF,
    parameter int FRACTION_BITS = ppc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rec_valid,
    output logic                        rec_pop,
    input  wire logic [VOLT_BITS-1:0]   dv_one,
    input  wire logic [VOLT_BITS-1:0]   span_one,
    input  wire logic [VOLT_BITS-1:0]   dv_two,
    input  wire logic [VOLT_BITS-1:0]   span_two,
    input  wire ppc_pkg::class_t        cls,
    input  wire logic [FRACTION_BITS:0] dis_limit,
    input  wire logic                   pop,
    output logic                        empty,
    output logic [FRACTION_BITS:0]      pedal_position,
    output logic                        brake_light_on,
    output logic                        sensor_fault,
    output logic                        brake_latched
);

    localparam int F  = FRACTION_BITS;
    localparam int CW = $clog2(F + 1);
    localparam logic [F:0] POS_ONE = {1'b1, {F{1'b0}}};

    ppc_pkg::back_state_t state_reg;
    ppc_pkg::back_state_t state_next;
    logic                 sel_reg;
    logic                 sel_next;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 fault_reg;
    logic                 fault_next;
    logic                 latch_reg;
    logic                 latch_next;

    logic [VOLT_BITS-1:0] dv1_reg;
    logic [VOLT_BITS-1:0] dv1_next;
    logic [VOLT_BITS-1:0] span1_reg;
    logic [VOLT_BITS-1:0] span1_next;
    logic [VOLT_BITS-1:0] dv2_reg;
    logic [VOLT_BITS-1:0] dv2_next;
    logic [VOLT_BITS-1:0] span2_reg;
    logic [VOLT_BITS-1:0] span2_next;
    ppc_pkg::class_t      cls_reg;
    ppc_pkg::class_t      cls_next;
    logic [VOLT_BITS-1:0] rem_reg;
    logic [VOLT_BITS-1:0] rem_next;
    logic [F-1:0]         quo_reg;
    logic [F-1:0]         quo_next;
    logic [F:0]           p1_reg;
    logic [F:0]           p1_next;
    logic [F:0]           p2_reg;
    logic [F:0]           p2_next;
    logic [F:0]           pos_reg;
    logic [F:0]           pos_next;
    logic                 light_reg;
    logic                 light_next;

    // Operands of the sensor currently being converted.
    logic [VOLT_BITS-1:0] cur_dv;
    logic [VOLT_BITS-1:0] cur_span;
    logic                 cur_zero;
    logic                 cur_sat;

    // One restoring division step.
    logic [VOLT_BITS:0]   rem_dbl;
    logic                 q_bit;
    logic [VOLT_BITS:0]   rem_sub;
    logic [F-1:0]         quo_shift;

    // Result forming.
    logic [F+1:0]         asum;
    logic [F:0]           diff;
    logic [F+5:0]         asum_x10;
    logic                 pedal_idle;
    logic                 fault_set;
    logic                 latch_set;

    assign cur_dv    = sel_reg ? dv2_reg : dv1_reg;
    assign cur_span  = sel_reg ? span2_reg : span1_reg;
    assign cur_zero  = sel_reg ? cls_reg.zero_two : cls_reg.zero_one;
    assign cur_sat   = sel_reg ? cls_reg.sat_two : cls_reg.sat_one;

    assign rem_dbl   = {rem_reg, 1'b0};
    assign q_bit     = rem_dbl >= {1'b0, cur_span};
    assign rem_sub   = rem_dbl - {1'b0, cur_span};
    assign quo_shift = {quo_reg[F-2:0], q_bit};

    assign asum       = {1'b0, p1_reg} + {1'b0, p2_reg};
    assign diff       = (p1_reg > p2_reg) ? p1_reg - p2_reg : p2_reg - p1_reg;
    assign asum_x10   = (F+6)'(asum) * (F+6)'(ppc_pkg::IDLE_SCALE);
    assign pedal_idle = asum_x10 <= {5'b0, POS_ONE};
    assign latch_set  = latch_reg | cls_reg.latch_set;
    assign fault_set  = fault_reg | (diff > dis_limit) | cls_reg.open_circuit;

    // Flags only change when a new result is loaded, so they serve as outputs.
    assign empty          = !out_valid_reg;
    assign pedal_position = pos_reg;
    assign brake_light_on = light_reg;
    assign sensor_fault   = fault_reg;
    assign brake_latched  = latch_reg;

    // Sequencer: take a word, convert both sensors, then form the result.
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        fault_next     = fault_reg;
        latch_next     = latch_reg;
        dv1_next       = dv1_reg;
        span1_next     = span1_reg;
        dv2_next       = dv2_reg;
        span2_next     = span2_reg;
        cls_next       = cls_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        pos_next       = pos_reg;
        light_next     = light_reg;
        rec_pop        = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ppc_pkg::ST_IDLE:
            begin
                if (rec_valid)
                begin
                    rec_pop    = 1'b1;
                    dv1_next   = dv_one;
                    span1_next = span_one;
                    dv2_next   = dv_two;
                    span2_next = span_two;
                    cls_next   = cls;
                    sel_next   = 1'b0;
                    state_next = ppc_pkg::ST_SETUP;
                end
            end

            ppc_pkg::ST_SETUP:
            begin
                if (cur_zero || cur_sat)
                begin
                    if (sel_reg)
                    begin
                        p2_next    = cur_zero ? '0 : POS_ONE;
                        state_next = ppc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        p1_next  = cur_zero ? '0 : POS_ONE;
                        sel_next = 1'b1;
                    end
                end
                else
                begin
                    rem_next   = cur_dv;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ppc_pkg::ST_DIV;
                end
            end

            ppc_pkg::ST_DIV:
            begin
                rem_next = q_bit ? rem_sub[VOLT_BITS-1:0] : rem_dbl[VOLT_BITS-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(F - 1))
                begin
                    if (sel_reg)
                    begin
                        p2_next    = {1'b0, quo_shift};
                        state_next = ppc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        p1_next    = {1'b0, quo_shift};
                        sel_next   = 1'b1;
                        state_next = ppc_pkg::ST_SETUP;
                    end
                end
            end

            ppc_pkg::ST_FINISH:
            begin
                // Wait for the result slot; latch first, then fault, then idle clear.
                if (!out_valid_reg || pop)
                begin
                    fault_next     = pedal_idle ? 1'b0 : fault_set;
                    latch_next     = pedal_idle ? 1'b0 : latch_set;
                    pos_next       = (pedal_idle || (!fault_set && !latch_set)) ?
                                     asum[F+1:1] : '0;
                    light_next     = cls_reg.light;
                    out_valid_next = 1'b1;
                    state_next     = ppc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ppc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppc_pkg::ST_IDLE;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            fault_reg     <= 1'b0;
            latch_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            fault_reg     <= fault_next;
            latch_reg     <= latch_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        dv1_reg   <= dv1_next;
        span1_reg <= span1_next;
        dv2_reg   <= dv2_next;
        span2_reg <= span2_next;
        cls_reg   <= cls_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        pos_reg   <= pos_next;
        light_reg <= light_next;
    end

    // A nonzero position is only shown while both sticky flags are clear.
    a_pos_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pos_reg != '0) |-> (!fault_reg && !latch_reg))
        else $error("position shown while faulted or latched");

    // The shown position never exceeds full pedal.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pos_reg <= POS_ONE))
        else $error("position above full scale");

    // The divider step count stays inside the quotient width.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ppc_pkg::ST_DIV) |-> (cnt_reg < CW'(F)))
        else $error("divider step count overrun");

    // A result is loaded only from the final state, leaving for idle.
    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ppc_pkg::ST_FINISH && (!out_valid_reg || pop))
        |=> (out_valid_reg && state_reg == ppc_pkg::ST_IDLE))
        else $error("result not loaded at finish");

endmodule

`default_nettype wire

### hw/rtl/pedal_plausibility_check_unit.sv
// Accelerator pedal plausibility check. Each input word (two throttle sensor
// voltages and two brake pressures) is classified on entry and queued two deep;
// a sequencer behind the queue converts each sensor voltage to a Q1.F position
// with one shared restoring divider that yields one quotient bit per cycle.
// A sensor at position 0 or full scale needs no division; when one does, that
// divider sets the rate, unless a result still waits to be taken. One result
// comes out per input word and waits on the result ports while empty is low.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data,
// always ready; all but the disagreement limit (used at finish) apply to words
// accepted afterward; write them only while the block holds no pending word.
`timescale 1ns / 1ps
`default_nettype none

module pedal_plausibility_check_unit #(
    parameter int VOLT_BITS     = ppc_pkg::VOLT_BITS_DEF,
    parameter int FRACTION_BITS = ppc_pkg::FRACTION_BITS_DEF,
    parameter int PRESSURE_BITS = ppc_pkg::PRESSURE_BITS_DEF,
    localparam int CFG_W_A      = (VOLT_BITS > FRACTION_BITS + 1) ?
                                  VOLT_BITS : FRACTION_BITS + 1,
    localparam int CFG_W        = (CFG_W_A > PRESSURE_BITS) ? CFG_W_A : PRESSURE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [VOLT_BITS-1:0]               sensor_one_volts,
    input  wire logic [VOLT_BITS-1:0]               sensor_two_volts,
    input  wire logic [PRESSURE_BITS-1:0]           front_pressure,
    input  wire logic [PRESSURE_BITS-1:0]           rear_pressure,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [FRACTION_BITS:0]                  pedal_position,
    output logic                                    brake_light_on,
    output logic                                    sensor_fault,
    output logic                                    brake_latched,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ppc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]                   cfg_data
);

    localparam int CLS_W = $bits(ppc_pkg::class_t);
    localparam int REC_W = 4 * VOLT_BITS + CLS_W;

    logic [VOLT_BITS-1:0]     s1_min_reg;
    logic [VOLT_BITS-1:0]     s1_max_reg;
    logic [VOLT_BITS-1:0]     s2_min_reg;
    logic [VOLT_BITS-1:0]     s2_max_reg;
    logic [FRACTION_BITS:0]   dis_limit_reg;
    logic [PRESSURE_BITS-1:0] light_level_reg;
    logic [PRESSURE_BITS-1:0] latch_level_reg;

    logic [VOLT_BITS-1:0]     f_dv_one;
    logic [VOLT_BITS-1:0]     f_span_one;
    logic [VOLT_BITS-1:0]     f_dv_two;
    logic [VOLT_BITS-1:0]     f_span_two;
    ppc_pkg::class_t          f_cls;

    logic                     q_full;
    logic                     q_empty;
    logic                     q_push;
    logic                     q_pop;
    logic [REC_W-1:0]         q_wr_data;
    logic [REC_W-1:0]         q_rd_data;

    logic [VOLT_BITS-1:0]     b_dv_one;
    logic [VOLT_BITS-1:0]     b_span_one;
    logic [VOLT_BITS-1:0]     b_dv_two;
    logic [VOLT_BITS-1:0]     b_span_two;
    ppc_pkg::class_t          b_cls;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_min_reg      <= VOLT_BITS'(ppc_pkg::RESET_S1_MIN);
            s1_max_reg      <= VOLT_BITS'(ppc_pkg::RESET_S1_MAX);
            s2_min_reg      <= VOLT_BITS'(ppc_pkg::RESET_S2_MIN);
            s2_max_reg      <= VOLT_BITS'(ppc_pkg::RESET_S2_MAX);
            dis_limit_reg   <= (FRACTION_BITS+1)'(ppc_pkg::RESET_DIS_LIMIT);
            light_level_reg <= PRESSURE_BITS'(ppc_pkg::RESET_LIGHT_LEVEL);
            latch_level_reg <= PRESSURE_BITS'(ppc_pkg::RESET_LATCH_LEVEL);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ppc_pkg::REG_S1_MIN:      s1_min_reg      <= cfg_data[VOLT_BITS-1:0];
                ppc_pkg::REG_S1_MAX:      s1_max_reg      <= cfg_data[VOLT_BITS-1:0];
                ppc_pkg::REG_S2_MIN:      s2_min_reg      <= cfg_data[VOLT_BITS-1:0];
                ppc_pkg::REG_S2_MAX:      s2_max_reg      <= cfg_data[VOLT_BITS-1:0];
                ppc_pkg::REG_DIS_LIMIT:   dis_limit_reg   <= cfg_data[FRACTION_BITS:0];
                ppc_pkg::REG_LIGHT_LEVEL: light_level_reg <= cfg_data[PRESSURE_BITS-1:0];
                ppc_pkg::REG_LATCH_LEVEL: latch_level_reg <= cfg_data[PRESSURE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front: classify the word as it is accepted.
    ppc_front #(
        .VOLT_BITS     (VOLT_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .PRESSURE_BITS (PRESSURE_BITS)
    ) u_front (
        .sensor_one_volts (sensor_one_volts),
        .sensor_two_volts (sensor_two_volts),
        .front_pressure   (front_pressure),
        .rear_pressure    (rear_pressure),
        .s1_min           (s1_min_reg),
        .s1_max           (s1_max_reg),
        .s2_min           (s2_min_reg),
        .s2_max           (s2_max_reg),
        .light_level      (light_level_reg),
        .latch_level      (latch_level_reg),
        .dv_one           (f_dv_one),
        .span_one         (f_span_one),
        .dv_two           (f_dv_two),
        .span_two         (f_span_two),
        .cls              (f_cls)
    );

    // Queue between the classifier and the divider side.
    assign full      = q_full;
    assign q_push    = push && !q_full;
    assign q_wr_data = {f_dv_one, f_span_one, f_dv_two, f_span_two, f_cls};

    ppc_fifo #(
        .WIDTH (REC_W),
        .DEPTH (ppc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign {b_dv_one, b_span_one, b_dv_two, b_span_two, b_cls} = q_rd_data;

    // Back: position conversion, sticky flags and the result slot.
    ppc_back #(
        .VOLT_BITS     (VOLT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rec_valid      (!q_empty),
        .rec_pop        (q_pop),
        .dv_one         (b_dv_one),
        .span_one       (b_span_one),
        .dv_two         (b_dv_two),
        .span_two       (b_span_two),
        .cls            (b_cls),
        .dis_limit      (dis_limit_reg),
        .pop            (pop),
        .empty          (empty),
        .pedal_position (pedal_position),
        .brake_light_on (brake_light_on),
        .sensor_fault   (sensor_fault),
        .brake_latched  (brake_latched)
    );

endmodule

`default_nettype wire

### tb/sv/pedal_result_checker.sv
`timescale 1ns / 1ps

module pedal_result_checker
    import ppc_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic                          full,
    input  wire logic [VOLT_BITS_DEF-1:0]      sensor_one_volts,
    input  wire logic [VOLT_BITS_DEF-1:0]      sensor_two_volts,
    input  wire logic [PRESSURE_BITS_DEF-1:0]  front_pressure,
    input  wire logic [PRESSURE_BITS_DEF-1:0]  rear_pressure,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire logic [FRACTION_BITS_DEF:0]    pedal_position,
    input  wire logic                          brake_light_on,
    input  wire logic                          sensor_fault,
    input  wire logic                          brake_latched,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [15:0]                   cfg_data,
    output int                                 mismatch_count,
    output int                                 words_pending
);

    localparam int VW = VOLT_BITS_DEF;
    localparam int FW = FRACTION_BITS_DEF;
    localparam int PW = PRESSURE_BITS_DEF;
    localparam int ONE_INT = 1 << FW;
    localparam logic [FW:0] FULL_SCALE = ONE_INT;

    typedef struct packed {
        logic [FW:0] position;
        logic        light;
        logic        fault;
        logic        latched;
    } pedal_result_t;

    // Calibration as the block should currently hold it.
    logic [VW-1:0] one_lo, one_hi, two_lo, two_hi;
    logic [FW:0]   agree_limit;
    logic [PW-1:0] light_level, latch_level;

    // Sticky flags as the block should currently hold them.
    logic fault_state, latch_state;

    pedal_result_t expected_results[$];
    int            failures;

    // Linear map of a sensor voltage onto 0 .. 1.0, clamped at both ends.
    function automatic logic [FW:0] volts_to_position(logic [VW-1:0] v, logic [VW-1:0] lo,
                                                      logic [VW-1:0] hi);
        logic [31:0] quotient;
        if (hi <= lo || v <= lo)
            return '0;
        quotient = (32'(v - lo) << FW) / 32'(hi - lo);
        return (quotient > ONE_INT) ? FULL_SCALE : quotient[FW:0];
    endfunction

    // Advance the sticky flags by one word and form the result it should give.
    function automatic pedal_result_t predict_word(logic [VW-1:0] v1, logic [VW-1:0] v2,
                                                   logic [PW-1:0] pa, logic [PW-1:0] pb);
        logic [FW:0]   pos_one, pos_two, spread;
        logic [FW+1:0] pos_sum;
        logic [PW:0]   pressure_sum;
        pedal_result_t r;
        pos_one = volts_to_position(v1, one_lo, one_hi);
        pos_two = volts_to_position(v2, two_lo, two_hi);
        spread = (pos_one > pos_two) ? pos_one - pos_two : pos_two - pos_one;
        pos_sum = {1'b0, pos_one} + {1'b0, pos_two};
        pressure_sum = {1'b0, pa} + {1'b0, pb};

        r.light = (pressure_sum >= 2 * light_level);
        if (pressure_sum >= 2 * latch_level)
            latch_state = 1'b1;
        if (spread > agree_limit || OPEN_SCALE * v1 <= ONE_INT || OPEN_SCALE * v2 <= ONE_INT)
            fault_state = 1'b1;
        // A released pedal clears both sticky flags.
        if (IDLE_SCALE * pos_sum <= ONE_INT)
        begin
            fault_state = 1'b0;
            latch_state = 1'b0;
        end
        r.position = (!fault_state && !latch_state) ? pos_sum[FW+1:1] : '0;
        r.fault = fault_state;
        r.latched = latch_state;
        return r;
    endfunction

    // Register writes; fields are cut to their widths, unknown indexes are dropped.
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index, logic [15:0] data);
        case (index)
            REG_S1_MIN:      one_lo = data[VW-1:0];
            REG_S1_MAX:      one_hi = data[VW-1:0];
            REG_S2_MIN:      two_lo = data[VW-1:0];
            REG_S2_MAX:      two_hi = data[VW-1:0];
            REG_DIS_LIMIT:   agree_limit = data[FW:0];
            REG_LIGHT_LEVEL: light_level = data[PW-1:0];
            REG_LATCH_LEVEL: latch_level = data[PW-1:0];
            default:         ;
        endcase
    endtask

    // Compare one result word with the oldest expectation.
    task automatic check_result();
        pedal_result_t want;
        bit            bad;
        bad = 1'b0;
        if (expected_results.size() == 0)
        begin
            $error("result word arrived with no expected word waiting");
            failures++;
            return;
        end
        want = expected_results.pop_front();
        if (pedal_position !== want.position)
        begin
            $error("pedal_position: expected %0d, actual %0d", want.position, pedal_position);
            bad = 1'b1;
        end
        if (brake_light_on !== want.light)
        begin
            $error("brake_light_on: expected %0b, actual %0b", want.light, brake_light_on);
            bad = 1'b1;
        end
        if (sensor_fault !== want.fault)
        begin
            $error("sensor_fault: expected %0b, actual %0b", want.fault, sensor_fault);
            bad = 1'b1;
        end
        if (brake_latched !== want.latched)
        begin
            $error("brake_latched: expected %0b, actual %0b", want.latched, brake_latched);
            bad = 1'b1;
        end
        if (bad)
            failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_lo = VW'(RESET_S1_MIN);
            one_hi = VW'(RESET_S1_MAX);
            two_lo = VW'(RESET_S2_MIN);
            two_hi = VW'(RESET_S2_MAX);
            agree_limit = (FW+1)'(RESET_DIS_LIMIT);
            light_level = PW'(RESET_LIGHT_LEVEL);
            latch_level = PW'(RESET_LATCH_LEVEL);
            fault_state = 1'b0;
            latch_state = 1'b0;
            expected_results.delete();
            failures = 0;
            mismatch_count <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (push && !full)
                expected_results.push_back(predict_word(sensor_one_volts, sensor_two_volts,
                                                        front_pressure, rear_pressure));
            if (pop && !empty)
                check_result();
            mismatch_count <= failures;
            words_pending <= expected_results.size();
        end
    end

endmodule

### tb/sv/pedal_plausibility_check_unit_tb.sv
`timescale 1ns / 1ps

module pedal_plausibility_check_unit_tb;

    import ppc_pkg::*;

    localparam int VW = VOLT_BITS_DEF;
    localparam int FW = FRACTION_BITS_DEF;
    localparam int PW = PRESSURE_BITS_DEF;
    localparam int CFG_BITS = 16;  // widest register field at the default widths
    localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 3'd7;
    localparam int SETTLE = 40;
    localparam int LONG_HOLD = 400;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic [VW-1:0]             sensor_one_volts;
    logic [VW-1:0]             sensor_two_volts;
    logic [PW-1:0]             front_pressure;
    logic [PW-1:0]             rear_pressure;
    logic                      empty;
    logic                      pop;
    logic [FW:0]               pedal_position;
    logic                      brake_light_on;
    logic                      sensor_fault;
    logic                      brake_latched;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;
    int                        mismatch_count;
    int                        words_pending;

    // Calibration last written, used only to aim the random words.
    int  aim_lo1, aim_hi1, aim_lo2, aim_hi2, aim_limit, aim_light, aim_latch;
    int  words_sent;
    bit  send_quiet;

    pedal_plausibility_check_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .sensor_one_volts (sensor_one_volts),
        .sensor_two_volts (sensor_two_volts),
        .front_pressure   (front_pressure),
        .rear_pressure    (rear_pressure),
        .empty            (empty),
        .pop              (pop),
        .pedal_position   (pedal_position),
        .brake_light_on   (brake_light_on),
        .sensor_fault     (sensor_fault),
        .brake_latched    (brake_latched),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    pedal_result_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .sensor_one_volts (sensor_one_volts),
        .sensor_two_volts (sensor_two_volts),
        .front_pressure   (front_pressure),
        .rear_pressure    (rear_pressure),
        .empty            (empty),
        .pop              (pop),
        .pedal_position   (pedal_position),
        .brake_light_on   (brake_light_on),
        .sensor_fault     (sensor_fault),
        .brake_latched    (brake_latched),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .words_pending    (words_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle lengths: mostly short, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int clip(int x, int hi);
        return (x < 0) ? 0 : ((x > hi) ? hi : x);
    endfunction

    // Offer one input word, wait for it to be taken, then maybe go idle.
    task automatic send_word(int v1, int v2, int pa, int pb);
        push <= 1'b1;
        sensor_one_volts <= VW'(v1);
        sensor_two_volts <= VW'(v2);
        front_pressure <= PW'(pa);
        rear_pressure <= PW'(pb);
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
        if (words_sent % 50 == 0)
            send_quiet = ($urandom_range(0, 3) == 0);
        if (!send_quiet && $urandom_range(0, 2) == 0)
        begin
            push <= 1'b0;
            repeat (pick_gap())
                @(posedge clk);
        end
    endtask

    // Mostly words that follow the calibration line with a bounded skew between
    // the sensors, plus released pedals, open circuits and raw noise.
    task automatic send_random_word();
        int mode, target, skew, v1, v2, pa, pb, base, pick;
        mode = $urandom_range(0, 15);
        target = (mode == 3) ? $urandom_range(0, 260) : $urandom_range(0, 4300);
        skew = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1200)
                                           : $urandom_range(0, aim_limit + 3);
        if ($urandom_range(0, 1) == 0)
            skew = -skew;
        v1 = clip(aim_lo1 + target * (aim_hi1 - aim_lo1) / 4096, 32767);
        v2 = clip(aim_lo2 + (target + skew) * (aim_hi2 - aim_lo2) / 4096, 32767);
        if (mode <= 1)
        begin
            v1 = $urandom_range(0, 32767);
            v2 = $urandom_range(0, 32767);
        end
        else if (mode == 2)
        begin
            if ($urandom_range(0, 1) == 0)
                v1 = $urandom_range(0, 45);
            else
                v2 = $urandom_range(0, 45);
        end

        // Pressures near the light level, near the latch level, or anywhere.
        pick = $urandom_range(0, 7);
        base = (pick < 4) ? aim_light : ((pick < 6) ? aim_latch : $urandom_range(0, 65535));
        pa = clip(base + $urandom_range(0, 40) - 20, 65535);
        pb = clip(base + $urandom_range(0, 40) - 20, 65535);
        if (pick == 7)
        begin
            pa = $urandom_range(0, 65535);
            pb = $urandom_range(0, 65535);
        end
        send_word(v1, v2, pa, pb);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, int data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= CFG_BITS'(data);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Write the whole calibration, preceded by a write to an unused index.
    task automatic calibrate(int lo1, int hi1, int lo2, int hi2, int limit, int light,
                             int latch);
        write_reg(REG_NONE, $urandom_range(0, 65535));
        write_reg(REG_S1_MIN, lo1);
        write_reg(REG_S1_MAX, hi1);
        write_reg(REG_S2_MIN, lo2);
        write_reg(REG_S2_MAX, hi2);
        write_reg(REG_DIS_LIMIT, limit);
        write_reg(REG_LIGHT_LEVEL, light);
        write_reg(REG_LATCH_LEVEL, latch);
        cfg_valid <= 1'b0;
        @(posedge clk);
        aim_lo1 = lo1 & 16'h7fff;
        aim_hi1 = hi1 & 16'h7fff;
        aim_lo2 = lo2 & 16'h7fff;
        aim_hi2 = hi2 & 16'h7fff;
        aim_limit = limit & 16'h1fff;
        aim_light = light;
        aim_latch = latch;
    endtask

    task automatic calibrate_random();
        int lo1, lo2, light;
        lo1 = $urandom_range(0, 10000);
        lo2 = $urandom_range(0, 10000);
        light = $urandom_range(0, 20000);
        calibrate(lo1, $urandom_range(lo1 + 200, 20479), lo2, $urandom_range(lo2 + 200, 20479),
                  $urandom_range(0, 4096), light, $urandom_range(light, 40000));
    endtask

    // Stop offering words and wait until every result word has been taken.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    // Result side: random stalls, calm stretches and two long hold-offs.
    initial
    begin : result_sink
        int popped;
        int hold_left;
        int next_hold;
        int cycle;
        bit quiet;
        popped = 0;
        hold_left = 0;
        next_hold = 150;
        cycle = 0;
        quiet = 1'b0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                popped++;
            cycle++;
            if (cycle % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (popped >= next_hold)
            begin
                // Hold off long enough for the block to fill and raise full.
                pop <= 1'b0;
                hold_left = LONG_HOLD - 1;
                next_hold += 850;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                pop <= 1'b0;
                hold_left = pick_gap() - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        sensor_one_volts <= '0;
        sensor_two_volts <= '0;
        front_pressure <= '0;
        rear_pressure <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        words_sent = 0;
        send_quiet = 1'b0;
        aim_lo1 = RESET_S1_MIN;
        aim_hi1 = RESET_S1_MAX;
        aim_lo2 = RESET_S2_MIN;
        aim_hi2 = RESET_S2_MAX;
        aim_limit = RESET_DIS_LIMIT;
        aim_light = RESET_LIGHT_LEVEL;
        aim_latch = RESET_LATCH_LEVEL;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: field extremes, saturation, and the edges of the
        // disagreement, released-pedal, light and latch thresholds.
        send_word(0, 0, 0, 0);
        send_word(32767, 32767, 65535, 65535);
        send_word(2048, 2048, 0, 0);
        send_word(10240, 10240, 1000, 999);
        send_word(10240, 10240, 1000, 1000);
        send_word(18432, 18432, 0, 0);
        send_word(32767, 30000, 0, 0);
        send_word(10240, 8600, 0, 0);
        send_word(10240, 8596, 0, 0);
        send_word(10240, 10240, 0, 0);
        send_word(2868, 2868, 0, 0);
        send_word(2868, 2864, 0, 0);
        send_word(10240, 10240, 4000, 3999);
        send_word(10240, 10240, 4000, 4000);
        send_word(12000, 12000, 0, 0);
        send_word(2048, 2048, 0, 0);
        repeat (300)
            send_random_word();
        drain();

        // Full-range spans, no disagreement, light only at maximum, latch always.
        calibrate(0, 20479, 0, 20479, 0, 65535, 0);
        repeat (215)
            send_random_word();
        drain();

        // Sensor one has a negative span; wide limit isolates the open-circuit test.
        calibrate(20479, 0, 0, 20479, 4096, 0, 65535);
        send_word(41, 15000, 0, 0);
        send_word(40, 15000, 0, 0);
        send_word(41, 15000, 0, 0);
        send_word(0, 0, 0, 0);
        send_word(41, 15000, 0, 0);
        repeat (215)
            send_random_word();
        drain();

        // Zero span on sensor one, negative span on sensor two.
        calibrate(8000, 8000, 18000, 3000, 2000, 30000, 30000);
        repeat (215)
            send_random_word();
        drain();

        // Bits above the register widths must be dropped.
        calibrate(16'h8000 | 2048, 16'h8000 | 18432, 16'h8000 | 1000, 16'h8000 | 16000,
                  16'he000 | 300, 800, 3000);
        repeat (215)
            send_random_word();
        drain();

        repeat (3)
        begin
            calibrate_random();
            repeat (215)
                send_random_word();
            drain();
        end

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
